>>> rtl/sha1_pkg.sv
// Shared constants, control structs and round functions for the SHA-1 digest block.
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned BUF_W       = WORD_W * NUM_WORDS;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned RND_W       = 7;
    localparam int unsigned LEN_POS     = 448 / 8;
    localparam int unsigned DIGEST_W    = 5 * WORD_W;
    localparam int unsigned COUNT_W     = 64;

    localparam logic [WORD_W-1:0] K_ROUND0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_ROUND3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] H_INIT0 = 32'h67452301;
    localparam logic [WORD_W-1:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H_INIT3 = 32'h10325476;
    localparam logic [WORD_W-1:0] H_INIT4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       step;
    } t_sched_ctl;

    typedef struct packed {
        logic             start;
        logic             round;
        logic [RND_W-1:0] rnd;
        logic             add;
        logic             reinit;
    } t_round_ctl;

    function automatic logic [WORD_W-1:0] f_round_k(input logic [RND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < RND_W'(20)) begin
            k = K_ROUND0;
        end else if (rnd < RND_W'(40)) begin
            k = K_ROUND1;
        end else if (rnd < RND_W'(60)) begin
            k = K_ROUND2;
        end else begin
            k = K_ROUND3;
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] f_round_f(input logic [RND_W-1:0]  rnd,
                                                    input logic [WORD_W-1:0] b,
                                                    input logic [WORD_W-1:0] c,
                                                    input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] f;
        if (rnd < RND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (rnd < RND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (rnd < RND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

>>> rtl/sha1_sched.sv
// Block buffer and message schedule: bytes shift in, then one schedule word per round.
`timescale 1ns / 1ps

module sha1_sched (
    input  logic                            i_clk,
    input  sha1_pkg::t_sched_ctl            i_ctl,
    output logic [sha1_pkg::WORD_W-1:0]     o_w
);

    localparam int unsigned WW = sha1_pkg::WORD_W;
    localparam int unsigned BW = sha1_pkg::BUF_W;

    // Word j of the window sits at bits [BW-1-WW*j -: WW]; word 0 is the current one.
    logic [BW-1:0] r_buf;
    logic [BW-1:0] n_buf;
    logic [WW-1:0] w_mix;

    assign w_mix = r_buf[BW-1 -: WW] ^ r_buf[BW-1-2*WW -: WW]
                 ^ r_buf[BW-1-8*WW -: WW] ^ r_buf[BW-1-13*WW -: WW];

    always_comb begin
        n_buf = r_buf;
        if (i_ctl.shift_byte) begin
            n_buf = {r_buf[BW-9:0], i_ctl.byte_val};
        end else if (i_ctl.step) begin
            n_buf = {r_buf[BW-WW-1:0], w_mix[WW-2:0], w_mix[WW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_w = r_buf[BW-1 -: WW];

endmodule

>>> rtl/sha1_round.sv
// Shared SHA-1 round unit with the working variables and the chaining words.
`timescale 1ns / 1ps

module sha1_round (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sha1_pkg::t_round_ctl            i_ctl,
    input  logic [sha1_pkg::WORD_W-1:0]     i_w,
    output logic [sha1_pkg::DIGEST_W-1:0]   o_sum
);

    localparam int unsigned WW = sha1_pkg::WORD_W;

    logic [WW-1:0] r_chain [5];
    logic [WW-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WW-1:0] w_t;
    logic [WW-1:0] w_sum [5];

    assign w_t = {r_a[WW-6:0], r_a[WW-1:WW-5]}
               + sha1_pkg::f_round_f(i_ctl.rnd, r_b, r_c, r_d)
               + r_e + sha1_pkg::f_round_k(i_ctl.rnd) + i_w;

    assign w_sum[0] = r_chain[0] + r_a;
    assign w_sum[1] = r_chain[1] + r_b;
    assign w_sum[2] = r_chain[2] + r_c;
    assign w_sum[3] = r_chain[3] + r_d;
    assign w_sum[4] = r_chain[4] + r_e;

    assign o_sum = {w_sum[0], w_sum[1], w_sum[2], w_sum[3], w_sum[4]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.round) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[WW-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.add && i_ctl.reinit)) begin
            r_chain[0] <= sha1_pkg::H_INIT0;
            r_chain[1] <= sha1_pkg::H_INIT1;
            r_chain[2] <= sha1_pkg::H_INIT2;
            r_chain[3] <= sha1_pkg::H_INIT3;
            r_chain[4] <= sha1_pkg::H_INIT4;
        end else if (i_ctl.add) begin
            for (int i = 0; i < 5; i++) begin
                r_chain[i] <= w_sum[i];
            end
        end
    end

endmodule

>>> rtl/sha1_message_digest.sv
// SHA-1 digest top level: byte intake, padding sequencer and digest output register.
//
// The input channel (i_valid / o_ready) moves one message byte per transfer, with
// i_final_byte set on the last byte of a message. The output channel (o_valid /
// i_ready) moves one 160-bit digest per message, split into high, mid and low words.
// A byte that completes a 64-byte block is stored, then the block runs through 80
// rounds on the shared round unit and is added into the chaining words. The final
// byte is followed by the pad and length bytes and one or two more compressions
// before the digest is registered. Intake pauses while a block is compressed on
// the single round unit.
// o_ready is high only while the sequencer is idle. A digest waits in the output
// register while the receiver stalls; the next message may start meanwhile, and
// only the digest step of that next message waits for the register to empty.
// After a digest the chaining words and the bit count return to their initial
// values. Reset (synchronous, active low) returns the block to the same state.
`timescale 1ns / 1ps

module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_high,
    output logic [63:0] o_digest_mid,
    output logic [31:0] o_digest_low
);

    localparam int unsigned POS_W   = sha1_pkg::POS_W;
    localparam int unsigned RND_W   = sha1_pkg::RND_W;
    localparam int unsigned CW      = sha1_pkg::COUNT_W;
    localparam int unsigned DW      = sha1_pkg::DIGEST_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(sha1_pkg::BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_POS  = POS_W'(sha1_pkg::LEN_POS);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(sha1_pkg::ROUNDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CW-1:0]      r_bit_count, n_bit_count;
    logic [RND_W-1:0]   r_rnd, n_rnd;
    logic               r_final, n_final;
    logic               r_pad_first, n_pad_first;
    logic               r_len, n_len;
    logic               r_pad_done, n_pad_done;
    logic               r_out_valid, n_out_valid;
    logic [DW-1:0]      r_digest, n_digest;

    sha1_pkg::t_sched_ctl         sched_ctl;
    sha1_pkg::t_round_ctl         round_ctl;
    logic [sha1_pkg::WORD_W-1:0]  w_word;
    logic [DW-1:0]                w_sum;
    logic                         accept;
    logic                         out_free;
    logic                         is_len;
    logic [CW-1:0]                len_shifted;
    logic [7:0]                   pad_byte;

    sha1_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w   (w_word)
    );

    sha1_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_w     (w_word),
        .o_sum   (w_sum)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Length bytes start at byte 56 of the first block in which byte 56 comes after the pad byte.
    assign is_len      = !r_pad_first && ((r_pos == LEN_POS) || r_len);
    assign len_shifted = r_bit_count >> {~r_pos[2:0], 3'b000};
    assign pad_byte    = r_pad_first ? sha1_pkg::PAD_BYTE :
                         (is_len ? len_shifted[7:0] : 8'h00);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_bit_count = r_bit_count;
        n_rnd       = r_rnd;
        n_final     = r_final;
        n_pad_first = r_pad_first;
        n_len       = r_len;
        n_pad_done  = r_pad_done;
        n_out_valid = r_out_valid && !i_ready;
        n_digest    = r_digest;
        sched_ctl   = '0;
        round_ctl   = '0;
        round_ctl.rnd = r_rnd;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    sched_ctl.shift_byte = 1'b1;
                    sched_ctl.byte_val   = i_data_byte;
                    n_pos       = r_pos + POS_W'(1);
                    n_bit_count = r_bit_count + CW'(8);
                    if (i_final_byte) begin
                        n_final     = 1'b1;
                        n_pad_first = 1'b1;
                    end
                    if (r_pos == LAST_POS) begin
                        round_ctl.start = 1'b1;
                        n_rnd   = '0;
                        n_state = ST_ROUND;
                    end else if (i_final_byte) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                round_ctl.round = 1'b1;
                sched_ctl.step  = 1'b1;
                if (r_rnd == LAST_RND) begin
                    n_state = ST_ADD;
                end else begin
                    n_rnd = r_rnd + RND_W'(1);
                end
            end
            ST_ADD: begin
                if (r_pad_done) begin
                    if (out_free) begin
                        round_ctl.add    = 1'b1;
                        round_ctl.reinit = 1'b1;
                        n_out_valid = 1'b1;
                        n_digest    = w_sum;
                        n_bit_count = '0;
                        n_final     = 1'b0;
                        n_len       = 1'b0;
                        n_pad_done  = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    round_ctl.add = 1'b1;
                    n_state = r_final ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                sched_ctl.shift_byte = 1'b1;
                sched_ctl.byte_val   = pad_byte;
                n_pos       = r_pos + POS_W'(1);
                n_pad_first = 1'b0;
                if (is_len) begin
                    n_len = 1'b1;
                end
                if (r_pos == LAST_POS) begin
                    round_ctl.start = 1'b1;
                    n_rnd   = '0;
                    n_state = ST_ROUND;
                    if (is_len) begin
                        n_pad_done = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_bit_count <= '0;
            r_rnd       <= '0;
            r_final     <= 1'b0;
            r_pad_first <= 1'b0;
            r_len       <= 1'b0;
            r_pad_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_bit_count <= n_bit_count;
            r_rnd       <= n_rnd;
            r_final     <= n_final;
            r_pad_first <= n_pad_first;
            r_len       <= n_len;
            r_pad_done  <= n_pad_done;
            r_out_valid <= n_out_valid;
        end
        r_digest <= n_digest;
    end

    assign o_valid       = r_out_valid;
    assign o_digest_high = r_digest[DW-1 -: 64];
    assign o_digest_mid  = r_digest[DW-65 -: 64];
    assign o_digest_low  = r_digest[31:0];

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd <= LAST_RND))
        else $error("round counter ran past the last round");

    a_pad_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> r_final)
        else $error("padding without a final byte");

    a_done_needs_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_done |-> (r_final && !r_pad_first))
        else $error("length written without a final byte and pad byte");

    a_digest_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_pad_done && out_free) |=>
            (r_out_valid && r_bit_count == '0 && r_pos == '0 && !r_final))
        else $error("digest step did not restore the message state");

endmodule
